FILE: design/atrk_pkg.sv
package atrk_pkg;

    // Table geometry
    localparam int ENTRIES   = 64;
    localparam int ADDR_BITS = 48;
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // Field widths
    localparam int ADDR_W  = 48;
    localparam int SIZE_W  = 32;
    localparam int TAG_W   = 8;
    localparam int LIVE_W  = 48;
    localparam int CNT_W   = 13;
    localparam int TOTAL_W = 32;
    localparam int KEY_W   = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;

    // Saturation limits
    localparam logic [LIVE_W-1:0]  LIVE_MAX  = {LIVE_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
    localparam logic [CNT_W-1:0]   CNT_MAX   = CNT_W'(ENTRIES);

    // Action codes
    localparam logic [1:0] ACT_REGISTER   = 2'd0;
    localparam logic [1:0] ACT_UNREGISTER = 2'd1;
    localparam logic [1:0] ACT_FIND       = 2'd2;
    localparam logic [1:0] ACT_CLEAR      = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_ABSENT  = 2'd3;

    typedef struct packed {
        logic [1:0]        action;
        logic [ADDR_W-1:0] address;
        logic [SIZE_W-1:0] byte_count;
        logic [TAG_W-1:0]  tag;
    } atrk_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               found;
        logic [SIZE_W-1:0]  found_size;
        logic [TAG_W-1:0]   found_tag;
        logic [LIVE_W-1:0]  live_bytes;
        logic [LIVE_W-1:0]  peak_bytes;
        logic [CNT_W-1:0]   live_count;
        logic [TOTAL_W-1:0] total_count;
    } atrk_out_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic scan;
        logic update;
        logic stats;
        logic load_out;
    } atrk_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic skip;
        logic scan_done;
    } atrk_stat_t;

endpackage

FILE: design/atrk_ctrl.sv
module atrk_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  atrk_pkg::atrk_stat_t stat,
    output atrk_pkg::atrk_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_UPD  = 5'b00100,
        S_STAT = 5'b01000,
        S_RESP = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;

    // Sequence one transaction: scan (skipped for clear and ignored actions), update, statistics, respond
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan = !stat.skip;
                if (stat.skip || stat.scan_done) begin
                    state_next = S_UPD;
                end
            end
            S_UPD: begin
                cmd.update = 1'b1;
                state_next = S_STAT;
            end
            S_STAT: begin
                cmd.stats  = 1'b1;
                state_next = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // One transaction at a time: no second accept right after the first
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a transaction is in progress");

    // Never overwrite a result that is still waiting
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten while stalled");

    // A loaded result is presented on the next cycle
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_valid_reg)
        else $error("loaded result not presented");

    // A finished scan always moves on to the update step
    a_scan_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN && stat.scan_done) |=> (state_reg == S_UPD))
        else $error("scan finished without update");

endmodule

FILE: design/atrk_dp.sv
module atrk_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  atrk_pkg::atrk_in_t   s_data,
    input  atrk_pkg::atrk_cmd_t  cmd,
    output atrk_pkg::atrk_stat_t stat,
    output atrk_pkg::atrk_out_t  m_data
);

    localparam int IDX_W  = atrk_pkg::IDX_W;
    localparam int KEY_W  = atrk_pkg::KEY_W;
    localparam int SIZE_W = atrk_pkg::SIZE_W;
    localparam int TAG_W  = atrk_pkg::TAG_W;
    localparam int LIVE_W = atrk_pkg::LIVE_W;
    localparam int CNT_W  = atrk_pkg::CNT_W;
    localparam int TOT_W  = atrk_pkg::TOTAL_W;
    localparam int N      = atrk_pkg::ENTRIES;

    // Table storage
    logic [KEY_W-1:0]  mem_addr [N];
    logic [SIZE_W-1:0] mem_size [N];
    logic [TAG_W-1:0]  mem_tag  [N];
    logic [N-1:0]      valid_reg;

    atrk_pkg::atrk_in_t  item_reg;
    atrk_pkg::atrk_out_t out_reg;

    // Scan pipeline
    logic [IDX_W:0]    idx_reg;
    logic              cmp_pend_reg;
    logic              rd_valid_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic [KEY_W-1:0]  rd_addr_reg;
    logic [SIZE_W-1:0] rd_size_reg;
    logic [TAG_W-1:0]  rd_tag_reg;

    // Scan results
    logic              hit_reg;
    logic [IDX_W-1:0]  hit_idx_reg;
    logic [SIZE_W-1:0] hit_size_reg;
    logic [TAG_W-1:0]  hit_tag_reg;
    logic              free_found_reg;
    logic [IDX_W-1:0]  free_idx_reg;

    // Statistics and result
    logic [LIVE_W-1:0] live_reg;
    logic [LIVE_W-1:0] peak_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [TOT_W-1:0]  total_reg;
    logic              add_pend_reg;
    logic [1:0]        res_status_reg;
    logic              res_found_reg;
    logic [SIZE_W-1:0] res_size_reg;
    logic [TAG_W-1:0]  res_tag_reg;

    logic [KEY_W-1:0]  key;
    logic              key_null;
    logic              issue_more;
    logic              match;
    logic              ign;

    // Update decode
    logic [1:0]        upd_status;
    logic              mem_we;
    logic [IDX_W-1:0]  wr_idx;
    logic              set_valid;
    logic              clr_valid;
    logic              clr_all;
    logic              take;
    logic              add;
    logic              cnt_inc;
    logic              cnt_dec;
    logic              fnd;
    logic [LIVE_W-1:0] hit_size_ext;
    logic [LIVE_W-1:0] live_off;
    logic [LIVE_W:0]   live_sum;
    logic [LIVE_W-1:0] live_add;

    assign key        = item_reg.address[KEY_W-1:0];
    assign key_null   = (key == '0);
    assign issue_more = (idx_reg < (IDX_W+1)'(N));
    assign match      = cmp_pend_reg && rd_valid_reg && (rd_addr_reg == key);
    assign ign        = key_null ||
                        ((item_reg.action == atrk_pkg::ACT_REGISTER) &&
                         (item_reg.byte_count == '0));

    assign stat.skip      = ign || (item_reg.action == atrk_pkg::ACT_CLEAR);
    assign stat.scan_done = !issue_more && !cmp_pend_reg;

    // Latch the incoming transaction
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            item_reg <= s_data;
        end
    end

    // Step the scan index and compare stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= '0;
            cmp_pend_reg <= 1'b0;
        end else if (cmd.accept) begin
            idx_reg      <= '0;
            cmp_pend_reg <= 1'b0;
        end else if (cmd.scan) begin
            cmp_pend_reg <= issue_more;
            if (issue_more) begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    // Read one entry per cycle, registered
    always_ff @(posedge aclk) begin
        if (cmd.scan && issue_more) begin
            rd_addr_reg  <= mem_addr[idx_reg[IDX_W-1:0]];
            rd_size_reg  <= mem_size[idx_reg[IDX_W-1:0]];
            rd_tag_reg   <= mem_tag[idx_reg[IDX_W-1:0]];
            rd_valid_reg <= valid_reg[idx_reg[IDX_W-1:0]];
            rd_idx_reg   <= idx_reg[IDX_W-1:0];
        end
    end

    // Record the match and the lowest free slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
        end else if (cmd.accept) begin
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
        end else if (cmd.scan && cmp_pend_reg) begin
            if (match && !hit_reg) begin
                hit_reg <= 1'b1;
            end
            if (!rd_valid_reg && !free_found_reg) begin
                free_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan && cmp_pend_reg) begin
            if (match && !hit_reg) begin
                hit_idx_reg  <= rd_idx_reg;
                hit_size_reg <= rd_size_reg;
                hit_tag_reg  <= rd_tag_reg;
            end
            if (!rd_valid_reg && !free_found_reg) begin
                free_idx_reg <= rd_idx_reg;
            end
        end
    end

    // Decide the table update for the action
    always_comb begin
        upd_status = atrk_pkg::ST_DONE;
        mem_we     = 1'b0;
        wr_idx     = hit_idx_reg;
        set_valid  = 1'b0;
        clr_valid  = 1'b0;
        clr_all    = 1'b0;
        take       = 1'b0;
        add        = 1'b0;
        cnt_inc    = 1'b0;
        cnt_dec    = 1'b0;
        fnd        = 1'b0;
        unique case (item_reg.action)
            atrk_pkg::ACT_REGISTER: begin
                if (ign) begin
                    upd_status = atrk_pkg::ST_IGNORED;
                end else if (hit_reg) begin
                    mem_we = 1'b1;
                    take   = 1'b1;
                    add    = 1'b1;
                end else if (free_found_reg) begin
                    wr_idx    = free_idx_reg;
                    mem_we    = 1'b1;
                    set_valid = 1'b1;
                    cnt_inc   = 1'b1;
                    add       = 1'b1;
                end else begin
                    upd_status = atrk_pkg::ST_FULL;
                end
            end
            atrk_pkg::ACT_UNREGISTER: begin
                if (ign) begin
                    upd_status = atrk_pkg::ST_IGNORED;
                end else if (hit_reg) begin
                    take      = 1'b1;
                    clr_valid = 1'b1;
                    cnt_dec   = 1'b1;
                end else begin
                    upd_status = atrk_pkg::ST_ABSENT;
                end
            end
            atrk_pkg::ACT_FIND: begin
                if (ign) begin
                    upd_status = atrk_pkg::ST_IGNORED;
                end else if (hit_reg) begin
                    fnd = 1'b1;
                end else begin
                    upd_status = atrk_pkg::ST_ABSENT;
                end
            end
            atrk_pkg::ACT_CLEAR: begin
                clr_all = 1'b1;
            end
            default: begin
                upd_status = atrk_pkg::ST_DONE;
            end
        endcase
    end

    // Take the old size off with a floor at zero
    assign hit_size_ext = LIVE_W'(hit_size_reg);
    assign live_off     = (live_reg >= hit_size_ext) ? (live_reg - hit_size_ext) : '0;

    // Add the new size, saturating
    assign live_sum = {1'b0, live_reg} + (LIVE_W+1)'(item_reg.byte_count);
    assign live_add = live_sum[LIVE_W] ? atrk_pkg::LIVE_MAX : live_sum[LIVE_W-1:0];

    // Write the table entry
    always_ff @(posedge aclk) begin
        if (cmd.update && mem_we) begin
            mem_addr[wr_idx] <= key;
            mem_size[wr_idx] <= item_reg.byte_count;
            mem_tag[wr_idx]  <= item_reg.tag;
        end
    end

    // Maintain valid bits and statistics
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            live_reg     <= '0;
            peak_reg     <= '0;
            count_reg    <= '0;
            total_reg    <= '0;
            add_pend_reg <= 1'b0;
        end else if (cmd.update) begin
            add_pend_reg <= add;
            if (clr_all) begin
                valid_reg <= '0;
                live_reg  <= '0;
                count_reg <= '0;
            end else begin
                if (set_valid) begin
                    valid_reg[wr_idx] <= 1'b1;
                end
                if (clr_valid) begin
                    valid_reg[wr_idx] <= 1'b0;
                end
                if (take) begin
                    live_reg <= live_off;
                end
                if (cnt_inc && (count_reg < atrk_pkg::CNT_MAX)) begin
                    count_reg <= count_reg + 1'b1;
                end
                if (cnt_dec && (count_reg != '0)) begin
                    count_reg <= count_reg - 1'b1;
                end
            end
        end else if (cmd.stats && add_pend_reg) begin
            add_pend_reg <= 1'b0;
            live_reg     <= live_add;
            if (live_add > peak_reg) begin
                peak_reg <= live_add;
            end
            if (total_reg != atrk_pkg::TOTAL_MAX) begin
                total_reg <= total_reg + 1'b1;
            end
        end
    end

    // Hold the per-transaction result fields
    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            res_status_reg <= upd_status;
            res_found_reg  <= fnd;
            res_size_reg   <= fnd ? hit_size_reg : '0;
            res_tag_reg    <= fnd ? hit_tag_reg : '0;
        end
    end

    // Load the output register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_reg.status      <= res_status_reg;
            out_reg.found       <= res_found_reg;
            out_reg.found_size  <= res_size_reg;
            out_reg.found_tag   <= res_tag_reg;
            out_reg.live_bytes  <= live_reg;
            out_reg.peak_bytes  <= peak_reg;
            out_reg.live_count  <= count_reg;
            out_reg.total_count <= total_reg;
        end
    end

    assign m_data = out_reg;

    // Live count always equals the number of valid entries in the table
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == CNT_W'($countones(valid_reg)))
        else $error("live count out of step with valid bits");

    // Peak never falls below live bytes once statistics settle
    a_peak_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        !add_pend_reg |-> (peak_reg >= live_reg))
        else $error("peak below live bytes");

endmodule

FILE: design/allocation_tracker_table_core.sv
// Allocation tracker table.
// Input channel s_valid/s_ready/s_data carries one action per transaction:
// register, unregister, find or clear. Output channel m_valid/m_ready/m_data
// returns exactly one result per action, with the live statistics after it.
// Every register (of non-zero size), unregister or find of a non-null key scans
// all ENTRIES slots, one per cycle through the registered table read port,
// then compares the last entry, closes the scan, and passes through the update,
// statistics and load steps. Clear and ignored (null key or zero size) actions
// skip the scan and go straight to the update, statistics and load steps.
// One transaction is in progress at a time; s_ready is high while idle.
// A result waits in the output register when the receiver stalls; the next
// transaction is accepted meanwhile and is held in its final step until the
// output register is free.
// Reset (aresetn low, synchronous) empties the table through its valid bits
// and zeroes all statistics at once; no clearing pass is needed.
module allocation_tracker_table_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  atrk_pkg::atrk_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output atrk_pkg::atrk_out_t m_data
);

    atrk_pkg::atrk_cmd_t  cmd;
    atrk_pkg::atrk_stat_t stat;

    atrk_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    atrk_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_data  (m_data)
    );

endmodule
